// File: rtl/core/psrq_pkg.sv
// ============================================================================
// psrq_pkg: shared types and constants for the progress synced release queue
// Sizes, command and event codes, beat structs and index helpers.
// ============================================================================
`default_nettype none

package psrq_pkg;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned MaxResults = 32;

  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned ResW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_PROGRESS = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    EV_SHOWN      = 2'd0,
    EV_RELEASED   = 2'd1,
    EV_DROP_STALE = 2'd2,
    EV_DROP_FULL  = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_DROP,
    ST_PROG,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] round_id;
    logic [31:0] seq_number;
    logic [15:0] text_handle;
    logic        text_nonempty;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] out_handle;
    logic [31:0] out_round;
    logic [31:0] out_seq;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic [31:0] round_id;
    logic [31:0] seq_number;
    logic [15:0] handle;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } ram_req_t;

  // Advance a ring index by one, wrapping at the queue depth.
  function automatic logic [IdxW-1:0] inc_idx(logic [IdxW-1:0] idx);
    return (idx == IdxW'(QueueDepth - 1)) ? '0 : idx + IdxW'(1);
  endfunction

  // Ring index base + offs, offs never above the queue depth.
  function automatic logic [IdxW-1:0] add_idx(logic [IdxW-1:0] base,
                                               logic [CntW-1:0] offs);
    logic [CntW:0] sum;
    sum = {{(CntW + 1 - IdxW){1'b0}}, base} + {1'b0, offs};
    if (sum >= (CntW + 1)'(QueueDepth)) begin
      sum = sum - (CntW + 1)'(QueueDepth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/progress_synced_release_queue.sv
// ============================================================================
// progress_synced_release_queue: ordered subtitle release queue
// Holds scheduled items in a ring buffer and releases or drops them as
// playback progress beats arrive.
// ============================================================================
//
//   channel | direction | beat type            | handshake
//   --------+-----------+----------------------+------------------------
//   in      | input     | psrq_pkg::in_item_t  | in_valid_i / in_ready_o
//   out     | output    | psrq_pkg::out_item_t | out_valid_o / out_ready_i
//
// One input beat is taken at a time; in_ready_o is high only in idle.
// Schedule: when the queue is full, the head is read from the RAM first.
// Progress: the scan reads one entry per cycle, unless an event waits on a
// stalled output, through the single read port of the entry RAM, and writes
// kept entries back. Output stalls can hold any step that emits a result.
// Reset clears the control state only; the entry RAM is never swept.
// ============================================================================
`default_nettype none

module progress_synced_release_queue (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire                 logic in_valid_i,
  output                      logic in_ready_o,
  input  wire  psrq_pkg::in_item_t  in_item_i,
  output                      logic out_valid_o,
  input  wire                 logic out_ready_i,
  output       psrq_pkg::out_item_t out_item_o
);
  import psrq_pkg::*;

  // Control and ring pointers.
  state_e          state_q, state_d;
  in_item_t        req_q, req_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic            prog_known_q, prog_known_d;
  logic [31:0]     prog_round_q, prog_round_d;
  logic [31:0]     prog_seq_q, prog_seq_d;

  // Scan bookkeeping: read pointer runs ahead, write pointer compacts.
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic [CntW-1:0] keep_q, keep_d;
  logic [ResW-1:0] nres_q, nres_d;

  // Pending event: held back one step so that last_result is known
  // before the beat is shown.
  logic            pend_v_q, pend_v_d;
  out_item_t       pend_q, pend_d;

  // Output register.
  logic            out_v_q, out_v_d;
  out_item_t       out_q, out_d;

  logic            push;
  out_item_t       push_item;
  logic            out_free;

  ram_req_t        ram_req;
  entry_t          ram_rdata;

  logic            sched_ok;
  logic            sched_now;
  logic            prog_ok;
  logic            ent_stale;
  logic            ent_ready;
  logic            ent_evt;
  logic            can_go;
  entry_t          new_entry;

  psrq_entry_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rdata_o(ram_rdata)
  );

  assign out_free  = !out_v_q || out_ready_i;

  assign new_entry = '{round_id:   req_q.round_id,
                       seq_number: req_q.seq_number,
                       handle:     req_q.text_handle};

  assign sched_ok  = req_q.text_nonempty && (req_q.round_id != '0) &&
                     (req_q.seq_number != '0);
  assign sched_now = prog_known_q && (prog_round_q == req_q.round_id) &&
                     (prog_seq_q >= req_q.seq_number);
  assign prog_ok   = (req_q.round_id != '0) && (req_q.seq_number != '0);

  // Classify the entry on the RAM read port against recorded progress.
  assign ent_stale = ram_rdata.round_id < prog_round_q;
  assign ent_ready = (ram_rdata.round_id == prog_round_q) &&
                     (ram_rdata.seq_number <= prog_seq_q);
  assign ent_evt   = (ent_stale || ent_ready) && (nres_q < ResW'(MaxResults));
  // An event may advance only if the pending one can move to the output.
  assign can_go    = !ent_evt || !pend_v_q || out_free;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    head_d       = head_q;
    count_d      = count_q;
    prog_known_d = prog_known_q;
    prog_round_d = prog_round_q;
    prog_seq_d   = prog_seq_q;
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    remain_d     = remain_q;
    keep_d       = keep_q;
    nres_d       = nres_q;
    pend_v_d     = pend_v_q;
    pend_d       = pend_q;
    push         = 1'b0;
    push_item    = pend_q;
    ram_req      = '0;
    in_ready_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d = in_item_i;
          unique case (cmd_e'(in_item_i.command))
            CMD_SCHEDULE: state_d = ST_SCHED;
            CMD_PROGRESS: state_d = ST_PROG;
            CMD_CLEAR: begin
              count_d      = '0;
              prog_known_d = 1'b0;
              prog_round_d = '0;
              prog_seq_d   = '0;
            end
            CMD_UNUSED: state_d = ST_IDLE;
          endcase
        end
      end

      ST_SCHED: begin
        priority if (!sched_ok) begin
          state_d = ST_IDLE;
        end else if (sched_now) begin
          if (out_free) begin
            push      = 1'b1;
            push_item = '{event_kind:  EV_SHOWN,
                          out_handle:  req_q.text_handle,
                          out_round:   req_q.round_id,
                          out_seq:     req_q.seq_number,
                          last_result: 1'b1};
            state_d   = ST_IDLE;
          end
        end else if (count_q == CntW'(QueueDepth)) begin
          // Full: fetch the oldest entry to report it.
          ram_req.re    = 1'b1;
          ram_req.raddr = head_q;
          state_d       = ST_DROP;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = add_idx(head_q, count_q);
          ram_req.wdata = new_entry;
          count_d       = count_q + CntW'(1);
          state_d       = ST_IDLE;
        end
      end

      ST_DROP: begin
        if (out_free) begin
          push      = 1'b1;
          push_item = '{event_kind:  EV_DROP_FULL,
                        out_handle:  ram_rdata.handle,
                        out_round:   ram_rdata.round_id,
                        out_seq:     ram_rdata.seq_number,
                        last_result: 1'b1};
          // New tail takes the freed head slot.
          ram_req.we    = 1'b1;
          ram_req.waddr = head_q;
          ram_req.wdata = new_entry;
          head_d        = inc_idx(head_q);
          state_d       = ST_IDLE;
        end
      end

      ST_PROG: begin
        if (!prog_ok) begin
          state_d = ST_IDLE;
        end else begin
          prog_known_d = 1'b1;
          prog_round_d = req_q.round_id;
          prog_seq_d   = req_q.seq_number;
          if (count_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = head_q;
            rd_idx_d      = inc_idx(head_q);
            wr_idx_d      = head_q;
            remain_d      = count_q;
            keep_d        = '0;
            nres_d        = '0;
            pend_v_d      = 1'b0;
            state_d       = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (can_go) begin
          if (ent_evt) begin
            if (pend_v_q) begin
              push      = 1'b1;
              push_item = pend_q;
            end
            pend_v_d = 1'b1;
            pend_d   = '{event_kind:  ent_stale ? EV_DROP_STALE : EV_RELEASED,
                         out_handle:  ram_rdata.handle,
                         out_round:   ram_rdata.round_id,
                         out_seq:     ram_rdata.seq_number,
                         last_result: 1'b0};
            nres_d   = nres_q + ResW'(1);
          end else begin
            // Keep: close up behind the read pointer.
            ram_req.we    = 1'b1;
            ram_req.waddr = wr_idx_q;
            ram_req.wdata = ram_rdata;
            wr_idx_d      = inc_idx(wr_idx_q);
            keep_d        = keep_q + CntW'(1);
          end
          if (remain_q == CntW'(1)) begin
            count_d = ent_evt ? keep_q : keep_q + CntW'(1);
            state_d = ST_FLUSH;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = rd_idx_q;
            rd_idx_d      = inc_idx(rd_idx_q);
            remain_d      = remain_q - CntW'(1);
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push                  = 1'b1;
          push_item             = pend_q;
          push_item.last_result = 1'b1;
          pend_v_d              = 1'b0;
          state_d               = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: load on push, drop once taken.
  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    if (push) begin
      out_v_d = 1'b1;
      out_d   = push_item;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      prog_known_q <= 1'b0;
      prog_round_q <= '0;
      prog_seq_q   <= '0;
      rd_idx_q     <= '0;
      wr_idx_q     <= '0;
      remain_q     <= '0;
      keep_q       <= '0;
      nres_q       <= '0;
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      prog_known_q <= prog_known_d;
      prog_round_q <= prog_round_d;
      prog_seq_q   <= prog_seq_d;
      rd_idx_q     <= rd_idx_d;
      wr_idx_q     <= wr_idx_d;
      remain_q     <= remain_d;
      keep_q       <= keep_d;
      nres_q       <= nres_d;
      pend_v_q     <= pend_v_d;
      out_v_q      <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/core/psrq_entry_ram.sv
// ============================================================================
// psrq_entry_ram: entry store of the release queue
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module psrq_entry_ram (
  input  wire                logic clk_i,
  input  wire  psrq_pkg::ram_req_t req_i,
  output       psrq_pkg::entry_t   rdata_o
);
  import psrq_pkg::*;

  entry_t mem [QueueDepth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Hold read data while no read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/psrq_checker.sv
// ============================================================================
// psrq_checker: port level checks for the release queue
// Watches the top level ports; attached by bind.
// ============================================================================
`default_nettype none

module psrq_checker (
  input  wire                 logic clk_i,
  input  wire                 logic rst_ni,
  input  wire                 logic in_valid_i,
  input  wire                 logic in_ready_o,
  input  wire  psrq_pkg::in_item_t  in_item_i,
  input  wire                 logic out_valid_o,
  input  wire                 logic out_ready_i,
  input  wire  psrq_pkg::out_item_t out_item_o
);
  import psrq_pkg::*;

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("psrq: stalled output beat changed");

  // A waiting input beat holds until taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("psrq: waiting input beat changed");

  // Immediate shows and full drops are the only result of their beat.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.event_kind == EV_SHOWN) ||
                    (out_item_o.event_kind == EV_DROP_FULL))
    |-> out_item_o.last_result)
    else $error("psrq: single event beat without last flag");

  // Only accepted schedules ever surface, so round and seq are nonzero.
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.out_round != '0) && (out_item_o.out_seq != '0))
    else $error("psrq: result with zero round or seq");

  // When a new beat can be taken, any waiting result closes its group.
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_item_o.last_result)
    else $error("psrq: input taken while a result group is open");

endmodule

bind progress_synced_release_queue psrq_checker u_psrq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

`default_nettype wire

// File: sim/progress_synced_release_queue_tb.sv
// ============================================================================
// progress_synced_release_queue_tb: self-checking bench for the release queue
// Drives schedule, progress and clear beats with random gaps, predicts every
// shown, released and dropped event in a shadow copy of the queue, and
// checks each output beat field by field against the oldest prediction.
// ============================================================================
`default_nettype none

module progress_synced_release_queue_tb;

  import psrq_pkg::*;

  // Limit on the whole run, in clock cycles.
  localparam int unsigned RunLimit = 300000;
  // Quiet cycles after the last event, covering a full scan.
  localparam int unsigned DrainCycles = 64;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Beats waiting to be driven, and events still owed by the block.
  in_item_t  beat_backlog[$];
  out_item_t events_due[$];

  // Shadow state: pending entries in order plus the last recorded progress.
  entry_t      shadow_q[$];
  logic        seen_known = 1'b0;
  logic [31:0] seen_round = '0;
  logic [31:0] seen_seq   = '0;

  int unsigned beats_in   = 0;
  int unsigned events_out = 0;
  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned kinds_seen[4];
  logic        calm;

  progress_synced_release_queue u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  // Hold both sides free of idling for a stretch in the middle of the run.
  assign calm = (beats_in >= 50) && (beats_in < 80);

  function automatic out_item_t event_of(event_e kind, entry_t e);
    out_item_t ev;
    ev.event_kind  = kind;
    ev.out_handle  = e.handle;
    ev.out_round   = e.round_id;
    ev.out_seq     = e.seq_number;
    ev.last_result = 1'b0;
    return ev;
  endfunction

  // Advance the shadow queue by one accepted beat and post its events.
  task automatic predict_events(in_item_t b);
    out_item_t burst[$];
    out_item_t ev;
    entry_t    kept[$];
    entry_t    e;
    logic      stale;
    logic      due;
    e = '{round_id: b.round_id, seq_number: b.seq_number, handle: b.text_handle};
    case (b.command)
      CMD_SCHEDULE: begin
        if (b.text_nonempty && b.round_id != '0 && b.seq_number != '0) begin
          if (seen_known && seen_round == b.round_id && seen_seq >= b.seq_number) begin
            // Progress already passed this item: show it at once.
            burst.push_back(event_of(EV_SHOWN, e));
          end else begin
            if (shadow_q.size() >= QueueDepth) begin
              // Full: drop the oldest entry to make room.
              burst.push_back(event_of(EV_DROP_FULL, shadow_q[0]));
              void'(shadow_q.pop_front());
            end
            shadow_q.push_back(e);
          end
        end
      end
      CMD_PROGRESS: begin
        if (b.round_id != '0 && b.seq_number != '0) begin
          seen_known = 1'b1;
          seen_round = b.round_id;
          seen_seq   = b.seq_number;
          // Walk in order; stop reporting at the result limit, keep the rest.
          foreach (shadow_q[i]) begin
            stale = shadow_q[i].round_id < b.round_id;
            due   = (shadow_q[i].round_id == b.round_id) &&
                    (shadow_q[i].seq_number <= b.seq_number);
            if ((stale || due) && burst.size() < MaxResults) begin
              if (stale) begin
                burst.push_back(event_of(EV_DROP_STALE, shadow_q[i]));
              end else begin
                burst.push_back(event_of(EV_RELEASED, shadow_q[i]));
              end
            end else begin
              kept.push_back(shadow_q[i]);
            end
          end
          shadow_q = kept;
        end
      end
      CMD_CLEAR: begin
        shadow_q.delete();
        seen_known = 1'b0;
        seen_round = '0;
        seen_seq   = '0;
      end
      default: begin
        // Unused command: nothing changes.
      end
    endcase
    foreach (burst[i]) begin
      ev = burst[i];
      ev.last_result = (i == burst.size() - 1);
      events_due.push_back(ev);
    end
  endtask

  task automatic queue_beat(cmd_e cmd, logic [31:0] rnd, logic [31:0] sq,
                            logic [15:0] hnd, logic nonempty);
    in_item_t b;
    b.command       = cmd;
    b.round_id      = rnd;
    b.seq_number    = sq;
    b.text_handle   = hnd;
    b.text_nonempty = nonempty;
    beat_backlog.push_back(b);
  endtask

  // Mostly small sequences so that comparisons hit; now and then full range.
  function automatic logic [31:0] pick_seq();
    if ($urandom_range(0, 99) < 80) begin
      return 32'($urandom_range(1, 16));
    end
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_handle();
    return 16'($urandom_range(0, 65535));
  endfunction

  // Input driver: hold a beat until taken, then load the next or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_events(in_item_i);
        beats_in <= beats_in + 1;
      end
      if (in_valid_i && !in_ready_o) begin
        // Hold valid and payload until the beat is taken.
      end else if (beat_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
        in_valid_i <= 1'b1;
        in_item_i  <= beat_backlog.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor: compare each taken beat with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        events_out <= events_out + 1;
        kinds_seen[out_item_o.event_kind] <= kinds_seen[out_item_o.event_kind] + 1;
        if (events_due.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected event: kind %0d handle %h round %h seq %h last %b",
                   $time, out_item_o.event_kind, out_item_o.out_handle,
                   out_item_o.out_round, out_item_o.out_seq, out_item_o.last_result);
        end else begin
          want = events_due.pop_front();
          if (out_item_o.event_kind  !== want.event_kind  ||
              out_item_o.out_handle  !== want.out_handle  ||
              out_item_o.out_round   !== want.out_round   ||
              out_item_o.out_seq     !== want.out_seq     ||
              out_item_o.last_result !== want.last_result) begin
            errors <= errors + 1;
            $display("%0t: event mismatch: expected kind %0d handle %h round %h seq %h last %b",
                     $time, want.event_kind, want.out_handle, want.out_round,
                     want.out_seq, want.last_result);
            $display("%0t:                 actual   kind %0d handle %h round %h seq %h last %b",
                     $time, out_item_o.event_kind, out_item_o.out_handle,
                     out_item_o.out_round, out_item_o.out_seq, out_item_o.last_result);
          end
        end
      end
      out_ready_i <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RunLimit) begin
      $display("%0t: timeout with %0d events still owed", $time, events_due.size());
      $display("progress_synced_release_queue test failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] rnd;
    logic [31:0] sq;
    int unsigned counted;
    int unsigned n;
    int unsigned pick;
    logic        filled;

    // Directed part: ignored beats, extremes, shown, released and stale events.
    queue_beat(CMD_UNUSED,   '1,            '1,            '1,       1'b1);
    queue_beat(CMD_SCHEDULE, 32'd0,         32'd5,         16'h0001, 1'b1);
    queue_beat(CMD_SCHEDULE, 32'd1,         32'd0,         16'h0002, 1'b1);
    queue_beat(CMD_SCHEDULE, 32'd1,         32'd1,         16'h0003, 1'b0);
    queue_beat(CMD_PROGRESS, 32'd0,         32'd5,         16'h0000, 1'b0);
    queue_beat(CMD_PROGRESS, 32'd5,         32'd0,         16'h0000, 1'b0);
    queue_beat(CMD_SCHEDULE, 32'd1,         32'd1,         16'h0000, 1'b1);
    queue_beat(CMD_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    queue_beat(CMD_SCHEDULE, 32'd2,         32'd3,         16'h1234, 1'b1);
    queue_beat(CMD_SCHEDULE, 32'd2,         32'd9,         16'hABCD, 1'b1);
    // Drop round 1 as stale, release (2,3), keep the rest.
    queue_beat(CMD_PROGRESS, 32'd2,         32'd3,         16'hFFFF, 1'b1);
    queue_beat(CMD_SCHEDULE, 32'd2,         32'd2,         16'h5A5A, 1'b1);
    queue_beat(CMD_SCHEDULE, 32'd2,         32'd4,         16'hA5A5, 1'b1);
    queue_beat(CMD_PROGRESS, 32'd2,         32'hFFFF_FFFF, 16'h0000, 1'b0);
    queue_beat(CMD_SCHEDULE, 32'hFFFF_FFFF, 32'd1,         16'h00FF, 1'b1);
    queue_beat(CMD_PROGRESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 1'b1);
    // Sequence equal to progress: shown at once.
    queue_beat(CMD_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFF00, 1'b1);
    queue_beat(CMD_CLEAR,    32'd0,         32'd0,         16'h0000, 1'b0);
    // Progress forgotten: this one queues, then clear empties it.
    queue_beat(CMD_SCHEDULE, 32'd3,         32'd1,         16'h0F0F, 1'b1);
    queue_beat(CMD_CLEAR,    '1,            '1,            '1,       1'b1);
    queue_beat(CMD_PROGRESS, 32'd1,         32'd1,         16'h0000, 1'b0);
    queue_beat(CMD_SCHEDULE, 32'd1,         32'd1,         16'h5555, 1'b1);

    // Random part: noise, clears, an overfill, and schedules then progress in a round.
    counted = 0;
    filled  = 1'b0;
    rnd     = 32'd10;
    while (counted < 75 || !filled) begin
      pick = $urandom_range(0, 9);
      if (!filled && counted >= 40) begin
        pick = 2;
      end
      // Advance the round mostly by small steps, sometimes jump.
      if ($urandom_range(0, 9) < 2) begin
        rnd = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 3))
                                          : $urandom;
      end else begin
        rnd = rnd + 32'($urandom_range(0, 2));
      end
      case (pick)
        0: begin
          // Noise: unused command, ignored schedule or ignored progress.
          n = $urandom_range(1, 3);
          repeat (n) begin
            case ($urandom_range(0, 4))
              0: queue_beat(CMD_UNUSED, $urandom, $urandom, pick_handle(),
                            1'($urandom_range(0, 1)));
              1: queue_beat(CMD_SCHEDULE, 32'd0, $urandom, pick_handle(), 1'b1);
              2: queue_beat(CMD_SCHEDULE, $urandom, 32'd0, pick_handle(), 1'b1);
              3: queue_beat(CMD_SCHEDULE, $urandom, $urandom, pick_handle(), 1'b0);
              default: begin
                if ($urandom_range(0, 1) != 0) begin
                  queue_beat(CMD_PROGRESS, 32'd0, $urandom, pick_handle(), 1'b1);
                end else begin
                  queue_beat(CMD_PROGRESS, $urandom, 32'd0, pick_handle(), 1'b0);
                end
              end
            endcase
          end
        end
        1: begin
          queue_beat(CMD_CLEAR, $urandom, $urandom, pick_handle(),
                     1'($urandom_range(0, 1)));
          counted++;
        end
        2: begin
          // Overfill a fresh round, then release the whole queue at once.
          rnd = rnd + 32'd1;
          n = QueueDepth + $urandom_range(1, 4);
          repeat (n) begin
            queue_beat(CMD_SCHEDULE, rnd, 32'($urandom_range(1, 16)), pick_handle(), 1'b1);
          end
          queue_beat(CMD_PROGRESS, rnd, 32'd16, pick_handle(), 1'($urandom_range(0, 1)));
          counted += n + 1;
          filled = 1'b1;
        end
        default: begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            case ($urandom_range(0, 5))
              0:       queue_beat(CMD_SCHEDULE, rnd - 32'd1, pick_seq(), pick_handle(), 1'b1);
              1:       queue_beat(CMD_SCHEDULE, rnd + 32'd1, pick_seq(), pick_handle(), 1'b1);
              default: queue_beat(CMD_SCHEDULE, rnd,         pick_seq(), pick_handle(), 1'b1);
            endcase
          end
          sq = pick_seq();
          queue_beat(CMD_PROGRESS, rnd, sq, pick_handle(), 1'($urandom_range(0, 1)));
          counted += n + 1;
          // Late schedules of the same round, some already due.
          n = $urandom_range(0, 2);
          repeat (n) begin
            queue_beat(CMD_SCHEDULE, rnd, 32'($urandom_range(1, 20)), pick_handle(), 1'b1);
          end
          counted += n;
        end
      endcase
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every beat to be taken, then for every owed event.
    while (beat_backlog.size() != 0 || in_valid_i) begin
      @(posedge clk_i);
    end
    while (events_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d input beats and %0d events: %0d shown, %0d released,",
             beats_in, events_out, kinds_seen[EV_SHOWN], kinds_seen[EV_RELEASED]);
    $display("%0d stale drops, %0d full-queue drops, %0d mismatches",
             kinds_seen[EV_DROP_STALE], kinds_seen[EV_DROP_FULL], errors);
    if (errors == 0) begin
      $display("progress_synced_release_queue test passed");
    end else begin
      $display("progress_synced_release_queue test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/core/psrq_pkg.sv
rtl/core/psrq_entry_ram.sv
rtl/core/progress_synced_release_queue.sv
rtl/core/psrq_checker.sv
sim/progress_synced_release_queue_tb.sv
